>>> hw/rtl/assert_macros.svh
// Assertion helpers shared by the RTL; build with NO_ASSERTIONS to drop them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Check a property on every clock edge outside of reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Check that a condition never holds outside of reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

>>> hw/rtl/hrlp_pkg.sv
`default_nettype none
package hrlp_pkg;

    // Longest method accepted is METHOD_CAPACITY-1 bytes
    localparam int METHOD_CAPACITY = 20;
    localparam int MLEN_W          = 6;
    localparam int PHASE_W         = 5;

    // Output item kinds
    localparam logic [2:0] KIND_NONE   = 3'd0;
    localparam logic [2:0] KIND_METHOD = 3'd1;
    localparam logic [2:0] KIND_PATH   = 3'd2;
    localparam logic [2:0] KIND_QUERY  = 3'd3;
    localparam logic [2:0] KIND_HEADER = 3'd4;

    // Parse status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_BAD       = 2'd1;
    localparam logic [1:0] ST_TOO_LARGE = 2'd2;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       new_request;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [2:0] out_kind;
        logic [1:0] parse_status;
        logic       in_headers;
        logic [7:0] major_version;
        logic [7:0] minor_version;
        logic       last_of_run;
    } t_out_item;

endpackage
`default_nettype wire

>>> hw/rtl/hrlp_in_if.sv
`default_nettype none
interface hrlp_in_if;
    logic                valid;
    logic                ready;
    hrlp_pkg::t_in_item  data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/hrlp_out_if.sv
`default_nettype none
interface hrlp_out_if;
    logic                valid;
    logic                ready;
    hrlp_pkg::t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/http_request_line_parser.sv
// HTTP request-line parser, one raw request byte per input item.
// i_in carries in_byte and new_request (clears the parse state first).
// o_out carries one to three result items per input byte: method, path
// or query data (percent escapes decoded), header passthrough bytes, or a
// single empty item; every item also shows status, header flag and the
// version numbers after that byte. last_of_run marks the final one.
// i_cfg_wr_en / i_cfg_wr_data write max_request_size (0 = unlimited);
// write it only while the block is idle.
// An accepted byte's first result item is presented in the cycle after it is taken.
// Throughput: one byte per cycle while each byte gives one result item
// and the receiver takes every item; a byte giving more items holds the input
// while the single output port drains the result buffer one item per cycle.
// The input is taken again in the cycle the last buffered item leaves.
// If the receiver stalls, the buffered items hold and the input stalls
// once the last item is waiting. Synchronous reset clears the parse
// state, the size limit and the result buffer.
`default_nettype none
`include "assert_macros.svh"
module http_request_line_parser (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    hrlp_in_if.sink          i_in,
    hrlp_out_if.source       o_out,
    input  wire logic        i_cfg_wr_en,
    input  wire logic [31:0] i_cfg_wr_data
);

    localparam int PW = hrlp_pkg::PHASE_W;
    localparam int MW = hrlp_pkg::MLEN_W;

    // Parse phases
    localparam logic [PW-1:0] PH_METHOD_WS = PW'(0);
    localparam logic [PW-1:0] PH_METHOD    = PW'(1);
    localparam logic [PW-1:0] PH_URL_WS    = PW'(2);
    localparam logic [PW-1:0] PH_SCHEME    = PW'(3);
    localparam logic [PW-1:0] PH_SLASH1    = PW'(4);
    localparam logic [PW-1:0] PH_SLASH2    = PW'(5);
    localparam logic [PW-1:0] PH_HOST      = PW'(6);
    localparam logic [PW-1:0] PH_PATH      = PW'(7);
    localparam logic [PW-1:0] PH_ESC       = PW'(8);
    localparam logic [PW-1:0] PH_QUERY     = PW'(9);
    localparam logic [PW-1:0] PH_VERSION   = PW'(10);
    localparam logic [PW-1:0] PH_MAJOR_WS  = PW'(11);
    localparam logic [PW-1:0] PH_MAJOR     = PW'(12);
    localparam logic [PW-1:0] PH_MAJOR_SP  = PW'(13);
    localparam logic [PW-1:0] PH_MINOR0    = PW'(14);
    localparam logic [PW-1:0] PH_MINOR     = PW'(15);
    localparam logic [PW-1:0] PH_END       = PW'(16);
    localparam logic [PW-1:0] PH_HEADER    = PW'(17);

    localparam logic [MW-1:0] MLEN_LIMIT = MW'(hrlp_pkg::METHOD_CAPACITY - 1);

    // Characters with a role of their own
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_LF      = 8'h0A;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_DOT     = 8'h2E;
    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_COLON   = 8'h3A;
    localparam logic [7:0] CH_QMARK   = 8'h3F;
    localparam logic [7:0] CH_LBRACK  = 8'h5B;
    localparam logic [7:0] CH_RBRACK  = 8'h5D;

    typedef struct packed {
        logic [PW-1:0] ph;
        logic          esc;
        logic          emit;
        logic          bad;
    } t_path_res;

    typedef struct packed {
        logic [PW-1:0] ph;
        logic [7:0]    acc;
        logic          bad;
    } t_ver_res;

    // ---------------- character classes ----------------
    function automatic logic is_letter(input logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        return c == CH_SPACE || c == CH_TAB;
    endfunction

    function automatic logic is_hex(input logic [7:0] c);
        return is_digit(c) || (c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66);
    endfunction

    function automatic logic is_method_char(input logic [7:0] c);
        logic mark;
        case (c) inside
            8'h22, 8'h28, 8'h29, 8'h2C, 8'h2F, 8'h3A, 8'h3B, 8'h3C, 8'h3D, 8'h3E,
            8'h3F, 8'h40, 8'h5B, 8'h5C, 8'h5D, 8'h7B, 8'h7D: mark = 1'b1;
            default: mark = 1'b0;
        endcase
        return mark || is_letter(c);
    endfunction

    function automatic logic [3:0] hex_value(input logic [7:0] c);
        logic [3:0] v;
        if (is_digit(c)) begin
            v = c[3:0];
        end else if (is_hex(c)) begin
            v = c[3:0] + 4'd9;
        end else begin
            v = 4'd0;
        end
        return v;
    endfunction

    function automatic logic [7:0] sat_decimal(input logic [7:0] acc, input logic [7:0] c);
        logic [11:0] v;
        v = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {8'd0, c[3:0]};
        return (v > 12'd255) ? 8'hFF : v[7:0];
    endfunction

    // Path byte handling, also used after an escape ends early
    function automatic t_path_res do_path(input logic [7:0] c);
        t_path_res r;
        r = '{ph: PH_PATH, esc: 1'b0, emit: 1'b0, bad: 1'b0};
        if (c == CH_QMARK) begin
            r.ph = PH_QUERY;
        end else if (c == CH_CR) begin
            r.ph = PH_END;
        end else if (c == CH_LF) begin
            r.ph = PH_HEADER;
        end else if (is_blank(c)) begin
            r.ph = PH_VERSION;
        end else if (c == CH_PERCENT) begin
            r.ph  = PH_ESC;
            r.esc = 1'b1;
        end else if (c > CH_SPACE) begin
            r.emit = 1'b1;
        end else begin
            r.bad = 1'b1;
        end
        return r;
    endfunction

    function automatic t_ver_res do_major(input logic [7:0] c, input logic [7:0] acc);
        t_ver_res r;
        r = '{ph: PH_MAJOR, acc: acc, bad: 1'b0};
        if (c == CH_DOT) begin
            r.ph = PH_MINOR0;
        end else if (is_digit(c)) begin
            r.acc = sat_decimal(acc, c);
        end else if (is_blank(c)) begin
            r.ph = PH_MAJOR_SP;
        end else begin
            r.bad = 1'b1;
        end
        return r;
    endfunction

    function automatic t_ver_res do_minor(input logic [7:0] c, input logic [7:0] acc);
        t_ver_res r;
        r = '{ph: PH_MINOR, acc: acc, bad: 1'b0};
        if (c == CH_LF) begin
            r.ph = PH_HEADER;
        end else if (is_blank(c) || c == CH_CR) begin
            r.ph = PH_END;
        end else if (is_digit(c)) begin
            r.acc = sat_decimal(acc, c);
        end else begin
            r.bad = 1'b1;
        end
        return r;
    endfunction

    // ---------------- registers ----------------
    logic [31:0]   r_max;
    logic [PW-1:0] r_ph;
    logic [MW-1:0] r_mlen;
    logic [1:0]    r_esc;
    logic [7:0]    r_held;
    logic [7:0]    r_maj;
    logic [7:0]    r_min;
    logic [31:0]   r_bytes;
    logic [1:0]    r_err;

    // Result buffer: up to three items of one byte, drained from slot 0
    logic [1:0]    r_cnt;
    logic [7:0]    r_obyte [3];
    logic [2:0]    r_okind [3];
    logic [1:0]    r_ostat;
    logic          r_ohdr;
    logic [7:0]    r_omaj;
    logic [7:0]    r_omin;

    logic [PW-1:0] n_ph;
    logic [MW-1:0] n_mlen;
    logic [1:0]    n_esc;
    logic [7:0]    n_held;
    logic [7:0]    n_maj;
    logic [7:0]    n_min;
    logic [31:0]   n_bytes;
    logic [1:0]    n_err;
    logic [7:0]    n_obyte [3];
    logic [2:0]    n_okind [3];
    logic [1:0]    n_cnt;

    logic          in_fire;
    logic          out_fire;
    logic [7:0]    c;
    logic          clr;
    logic [PW-1:0] cur_ph;
    logic [MW-1:0] cur_mlen;
    logic [1:0]    cur_esc;
    logic [7:0]    cur_held;
    logic [7:0]    cur_maj;
    logic [7:0]    cur_min;
    logic [31:0]   cur_bytes;
    logic [1:0]    cur_err;
    logic          bad;
    t_path_res     pr;
    t_ver_res      vr;
    logic [7:0]    dec;

    // Handshakes: take a byte when the buffer is empty or empties this cycle
    assign out_fire   = o_out.valid && o_out.ready;
    assign in_fire    = i_in.valid && i_in.ready;
    assign i_in.ready = (r_cnt == 2'd0) || (r_cnt == 2'd1 && o_out.ready);

    // State seen by this byte, after an optional clear
    assign c         = i_in.data.in_byte;
    assign clr       = i_in.data.new_request;
    assign cur_ph    = clr ? PH_METHOD_WS : r_ph;
    assign cur_mlen  = clr ? '0 : r_mlen;
    assign cur_esc   = clr ? 2'd0 : r_esc;
    assign cur_held  = clr ? 8'd0 : r_held;
    assign cur_maj   = clr ? 8'd0 : r_maj;
    assign cur_min   = clr ? 8'd0 : r_min;
    assign cur_bytes = clr ? 32'd0 : r_bytes;
    assign cur_err   = clr ? hrlp_pkg::ST_OK : r_err;
    assign pr        = do_path(c);
    assign dec       = {hex_value(cur_held), hex_value(c)};

    // Next parse state and the result items of this byte
    always_comb begin
        n_ph    = cur_ph;
        n_mlen  = cur_mlen;
        n_esc   = cur_esc;
        n_held  = cur_held;
        n_maj   = cur_maj;
        n_min   = cur_min;
        n_bytes = cur_bytes;
        n_err   = cur_err;
        bad     = 1'b0;
        vr      = '{ph: cur_ph, acc: 8'd0, bad: 1'b0};
        n_cnt   = 2'd0;
        for (int k = 0; k < 3; k++) begin
            n_obyte[k] = 8'd0;
            n_okind[k] = hrlp_pkg::KIND_NONE;
        end

        if (cur_err == hrlp_pkg::ST_OK) begin
            unique case (cur_ph) inside
                PH_METHOD_WS: begin
                    if (is_method_char(c)) begin
                        n_obyte[n_cnt] = c;
                        n_okind[n_cnt] = hrlp_pkg::KIND_METHOD;
                        n_cnt          = n_cnt + 2'd1;
                        n_mlen         = MW'(1);
                        n_ph           = PH_METHOD;
                    end else if (!is_blank(c)) begin
                        bad = 1'b1;
                    end
                end
                PH_METHOD: begin
                    if (is_method_char(c)) begin
                        if (cur_mlen >= MLEN_LIMIT) begin
                            bad = 1'b1;
                        end else begin
                            n_obyte[n_cnt] = c;
                            n_okind[n_cnt] = hrlp_pkg::KIND_METHOD;
                            n_cnt          = n_cnt + 2'd1;
                            n_mlen         = cur_mlen + MW'(1);
                        end
                    end else if (c == CH_SPACE) begin
                        n_ph = PH_URL_WS;
                    end else begin
                        bad = 1'b1;
                    end
                end
                PH_URL_WS: begin
                    if (is_blank(c)) begin
                        n_ph = cur_ph;
                    end else if (c == CH_SLASH) begin
                        n_obyte[n_cnt] = c;
                        n_okind[n_cnt] = hrlp_pkg::KIND_PATH;
                        n_cnt          = n_cnt + 2'd1;
                        n_ph           = PH_PATH;
                    end else if (is_letter(c)) begin
                        n_ph = PH_SCHEME;
                    end else begin
                        bad = 1'b1;
                    end
                end
                PH_SCHEME: begin
                    if (c == CH_COLON) begin
                        n_ph = PH_SLASH1;
                    end else if (!is_letter(c)) begin
                        bad = 1'b1;
                    end
                end
                PH_SLASH1: begin
                    if (c == CH_SLASH) begin
                        n_ph = PH_SLASH2;
                    end else begin
                        bad = 1'b1;
                    end
                end
                PH_SLASH2: begin
                    if (c == CH_SLASH) begin
                        n_ph = PH_HOST;
                    end else begin
                        bad = 1'b1;
                    end
                end
                PH_HOST: begin
                    if (c == CH_SLASH) begin
                        n_obyte[n_cnt] = c;
                        n_okind[n_cnt] = hrlp_pkg::KIND_PATH;
                        n_cnt          = n_cnt + 2'd1;
                        n_ph           = PH_PATH;
                    end else if (!is_letter(c) && !is_digit(c) && c != CH_LBRACK
                                 && c != CH_RBRACK && c != CH_DOT && c != CH_COLON) begin
                        bad = 1'b1;
                    end
                end
                PH_PATH: begin
                    n_ph = pr.ph;
                    if (pr.esc) begin
                        n_esc = 2'd1;
                    end
                    if (pr.emit) begin
                        n_obyte[n_cnt] = c;
                        n_okind[n_cnt] = hrlp_pkg::KIND_PATH;
                        n_cnt          = n_cnt + 2'd1;
                    end
                    bad = pr.bad;
                end
                PH_ESC: begin
                    if (is_hex(c) && cur_esc == 2'd1) begin
                        n_held = c;
                        n_esc  = 2'd2;
                    end else if (is_hex(c) && cur_esc == 2'd2) begin
                        n_esc  = 2'd0;
                        n_held = 8'd0;
                        n_ph   = PH_PATH;
                        if (dec == 8'd0) begin
                            bad = 1'b1;
                        end else begin
                            n_obyte[n_cnt] = dec;
                            n_okind[n_cnt] = hrlp_pkg::KIND_PATH;
                            n_cnt          = n_cnt + 2'd1;
                        end
                    end else begin
                        // Escape ended early: flush '%' and any held digit
                        n_obyte[n_cnt] = CH_PERCENT;
                        n_okind[n_cnt] = hrlp_pkg::KIND_PATH;
                        n_cnt          = n_cnt + 2'd1;
                        if (cur_esc == 2'd2) begin
                            n_obyte[n_cnt] = cur_held;
                            n_okind[n_cnt] = hrlp_pkg::KIND_PATH;
                            n_cnt          = n_cnt + 2'd1;
                        end
                        n_esc  = pr.esc ? 2'd1 : 2'd0;
                        n_held = 8'd0;
                        n_ph   = pr.ph;
                        if (pr.emit) begin
                            n_obyte[n_cnt] = c;
                            n_okind[n_cnt] = hrlp_pkg::KIND_PATH;
                            n_cnt          = n_cnt + 2'd1;
                        end
                        bad = pr.bad;
                    end
                end
                PH_QUERY: begin
                    if (is_blank(c)) begin
                        n_ph = PH_VERSION;
                    end else begin
                        n_obyte[n_cnt] = c;
                        n_okind[n_cnt] = hrlp_pkg::KIND_QUERY;
                        n_cnt          = n_cnt + 2'd1;
                    end
                end
                PH_VERSION: begin
                    if (c == CH_SLASH) begin
                        n_maj = 8'd0;
                        n_min = 8'd0;
                        n_ph  = PH_MAJOR_WS;
                    end else if (c == CH_CR) begin
                        bad = 1'b1;
                    end
                end
                PH_MAJOR_WS, PH_MAJOR: begin
                    if (cur_ph == PH_MAJOR || !is_blank(c)) begin
                        vr    = do_major(c, cur_maj);
                        n_ph  = vr.ph;
                        n_maj = vr.acc;
                        bad   = vr.bad;
                    end
                end
                PH_MAJOR_SP: begin
                    if (c == CH_DOT) begin
                        n_ph = PH_MINOR0;
                    end else begin
                        bad = 1'b1;
                    end
                end
                PH_MINOR0, PH_MINOR: begin
                    if (cur_ph == PH_MINOR || !is_blank(c)) begin
                        vr    = do_minor(c, cur_min);
                        n_ph  = vr.ph;
                        n_min = vr.acc;
                        bad   = vr.bad;
                    end
                end
                PH_END: begin
                    if (c == CH_LF) begin
                        n_ph = PH_HEADER;
                    end else if (!is_blank(c)) begin
                        bad = 1'b1;
                    end
                end
                PH_HEADER: begin
                    n_obyte[n_cnt] = c;
                    n_okind[n_cnt] = hrlp_pkg::KIND_HEADER;
                    n_cnt          = n_cnt + 2'd1;
                end
                default: begin
                    n_ph = PH_METHOD_WS;
                end
            endcase

            if (bad) begin
                n_err = hrlp_pkg::ST_BAD;
            end
            // Count the byte, saturating, and check the size limit
            if (cur_bytes != 32'hFFFF_FFFF) begin
                n_bytes = cur_bytes + 32'd1;
            end
            if (r_max != 32'd0 && n_bytes > r_max) begin
                n_err = hrlp_pkg::ST_TOO_LARGE;
            end
        end

        // A byte with no data still gives one empty item
        if (n_cnt == 2'd0) begin
            n_cnt = 2'd1;
        end
    end

    // Hold the size limit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max <= 32'd0;
        end else if (i_cfg_wr_en) begin
            r_max <= i_cfg_wr_data;
        end
    end

    // Advance the parse state on each accepted item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph    <= PH_METHOD_WS;
            r_mlen  <= '0;
            r_esc   <= 2'd0;
            r_held  <= 8'd0;
            r_maj   <= 8'd0;
            r_min   <= 8'd0;
            r_bytes <= 32'd0;
            r_err   <= hrlp_pkg::ST_OK;
        end else if (in_fire) begin
            r_ph    <= n_ph;
            r_mlen  <= n_mlen;
            r_esc   <= n_esc;
            r_held  <= n_held;
            r_maj   <= n_maj;
            r_min   <= n_min;
            r_bytes <= n_bytes;
            r_err   <= n_err;
        end
    end

    // Load the result buffer, or drop the item just taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else if (in_fire) begin
            r_cnt <= n_cnt;
        end else if (out_fire) begin
            r_cnt <= r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            for (int k = 0; k < 3; k++) begin
                r_obyte[k] <= n_obyte[k];
                r_okind[k] <= n_okind[k];
            end
            r_ostat <= n_err;
            r_ohdr  <= (n_ph == PH_HEADER);
            r_omaj  <= n_maj;
            r_omin  <= n_min;
        end else if (out_fire) begin
            r_obyte[0] <= r_obyte[1];
            r_okind[0] <= r_okind[1];
            r_obyte[1] <= r_obyte[2];
            r_okind[1] <= r_okind[2];
        end
    end

    // Present slot 0
    assign o_out.valid              = (r_cnt != 2'd0);
    assign o_out.data.out_byte      = r_obyte[0];
    assign o_out.data.out_kind      = r_okind[0];
    assign o_out.data.parse_status  = r_ostat;
    assign o_out.data.in_headers    = r_ohdr;
    assign o_out.data.major_version = r_omaj;
    assign o_out.data.minor_version = r_omin;
    assign o_out.data.last_of_run   = (r_cnt == 2'd1);

    `ASSERT_CLK(a_fire_fills, i_clk, i_rst_n, in_fire |=> r_cnt != 2'd0, "accepted byte left no result")
    `ASSERT_CLK(a_err_sticky, i_clk, i_rst_n, (r_err != hrlp_pkg::ST_OK && !(in_fire && clr)) |=> r_err == $past(r_err), "error code changed without a new request")
    `ASSERT_NEVER(a_empty_single, i_clk, i_rst_n, o_out.valid && r_okind[0] == hrlp_pkg::KIND_NONE && r_cnt != 2'd1, "empty item not alone")

endmodule
`default_nettype wire

>>> bench/hrlp_line_checker.sv
`timescale 1ns / 1ps
module hrlp_line_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    hrlp_in_if               i_req_ch,
    hrlp_out_if              i_res_ch,
    input  wire logic        i_cfg_wr_en,
    input  wire logic [31:0] i_cfg_wr_data,
    output int               o_fail_count,
    output int               o_pending
);

    localparam int MAX_REPORTS = 10;

    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_QMARK = 8'h3F;
    localparam logic [7:0] CH_LBRK  = 8'h5B;
    localparam logic [7:0] CH_RBRK  = 8'h5D;

    typedef enum logic [4:0] {
        LN_METHOD_WS, LN_METHOD, LN_URL_WS, LN_SCHEME, LN_SLASH1, LN_SLASH2,
        LN_HOST, LN_PATH, LN_ESC, LN_QUERY, LN_VERSION, LN_MAJOR_WS, LN_MAJOR,
        LN_MAJOR_SP, LN_MINOR0, LN_MINOR, LN_END, LN_HEADER
    } t_line_phase;

    // Mirror of the parser state and the size limit register
    t_line_phase line_phase   = LN_METHOD_WS;
    logic [5:0]  method_len   = '0;
    logic [1:0]  esc_pending  = '0;
    logic [7:0]  held_digit   = '0;
    logic [7:0]  major_acc    = '0;
    logic [7:0]  minor_acc    = '0;
    logic [31:0] byte_count   = '0;
    logic [1:0]  line_status  = hrlp_pkg::ST_OK;
    logic [31:0] size_limit   = '0;

    // Data bytes produced by the byte under work
    logic [7:0]  data_byte [3];
    logic [2:0]  data_kind [3];
    int          data_n;

    hrlp_pkg::t_out_item expected_items [$];
    int                  fail_total = 0;

    function automatic logic is_letter(input logic [7:0] c);
        return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        return c == CH_SP || c == CH_TAB;
    endfunction

    function automatic logic is_hex(input logic [7:0] c);
        return is_digit(c) || (c >= "A" && c <= "F") || (c >= "a" && c <= "f");
    endfunction

    function automatic logic is_method_char(input logic [7:0] c);
        if (is_letter(c)) begin
            return 1'b1;
        end
        case (c)
            "\"", "(", ")", ",", "/", ":", ";", "<", "=", ">", "?", "@", "[",
            "\\", "]", "{", "}": return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    function automatic logic [3:0] hex_val(input logic [7:0] c);
        logic [7:0] v;
        if (is_digit(c)) v = c - "0";
        else if (c >= "a" && c <= "f") v = c - "a" + 8'd10;
        else v = c - "A" + 8'd10;
        return v[3:0];
    endfunction

    // Accumulate one decimal digit, saturate at 255
    function automatic logic [7:0] add_digit(input logic [7:0] acc, input logic [7:0] c);
        int v;
        v = int'(acc) * 10 + int'(c) - 48;
        return (v > 255) ? 8'd255 : v[7:0];
    endfunction

    function automatic void add_data(input logic [7:0] b, input logic [2:0] k);
        if (data_n < 3) begin
            data_byte[data_n] = b;
            data_kind[data_n] = k;
            data_n++;
        end
    endfunction

    function automatic void flag_bad();
        line_status = hrlp_pkg::ST_BAD;
    endfunction

    function automatic void clear_line();
        line_phase  = LN_METHOD_WS;
        method_len  = '0;
        esc_pending = '0;
        held_digit  = '0;
        major_acc   = '0;
        minor_acc   = '0;
        byte_count  = '0;
        line_status = hrlp_pkg::ST_OK;
    endfunction

    function automatic void path_byte(input logic [7:0] c);
        if (c == CH_QMARK) line_phase = LN_QUERY;
        else if (c == CH_CR) line_phase = LN_END;
        else if (c == CH_LF) line_phase = LN_HEADER;
        else if (is_blank(c)) line_phase = LN_VERSION;
        else if (c == CH_PCT) begin
            line_phase  = LN_ESC;
            esc_pending = 2'd1;
        end else if (c > CH_SP) add_data(c, hrlp_pkg::KIND_PATH);
        else flag_bad();
    endfunction

    function automatic void major_byte(input logic [7:0] c);
        line_phase = LN_MAJOR;
        if (c == CH_DOT) line_phase = LN_MINOR0;
        else if (is_digit(c)) major_acc = add_digit(major_acc, c);
        else if (is_blank(c)) line_phase = LN_MAJOR_SP;
        else flag_bad();
    endfunction

    function automatic void minor_byte(input logic [7:0] c);
        line_phase = LN_MINOR;
        if (c == CH_LF) line_phase = LN_HEADER;
        else if (is_blank(c) || c == CH_CR) line_phase = LN_END;
        else if (is_digit(c)) minor_acc = add_digit(minor_acc, c);
        else flag_bad();
    endfunction

    // Advance the request-line state by one byte
    function automatic void parse_byte(input logic [7:0] c);
        logic [7:0] decoded;
        case (line_phase)
            LN_METHOD_WS: begin
                if (is_method_char(c)) begin
                    add_data(c, hrlp_pkg::KIND_METHOD);
                    method_len = 6'd1;
                    line_phase = LN_METHOD;
                end else if (!is_blank(c)) flag_bad();
            end
            LN_METHOD: begin
                if (is_method_char(c)) begin
                    if (int'(method_len) >= hrlp_pkg::METHOD_CAPACITY - 1) flag_bad();
                    else begin
                        add_data(c, hrlp_pkg::KIND_METHOD);
                        method_len++;
                    end
                end else if (c == CH_SP) line_phase = LN_URL_WS;
                else flag_bad();
            end
            LN_URL_WS: begin
                if (!is_blank(c)) begin
                    if (c == CH_SLASH) begin
                        add_data(c, hrlp_pkg::KIND_PATH);
                        line_phase = LN_PATH;
                    end else if (is_letter(c)) line_phase = LN_SCHEME;
                    else flag_bad();
                end
            end
            LN_SCHEME: begin
                if (c == CH_COLON) line_phase = LN_SLASH1;
                else if (!is_letter(c)) flag_bad();
            end
            LN_SLASH1: begin
                if (c == CH_SLASH) line_phase = LN_SLASH2;
                else flag_bad();
            end
            LN_SLASH2: begin
                if (c == CH_SLASH) line_phase = LN_HOST;
                else flag_bad();
            end
            LN_HOST: begin
                if (c == CH_SLASH) begin
                    add_data(c, hrlp_pkg::KIND_PATH);
                    line_phase = LN_PATH;
                end else if (!is_letter(c) && !is_digit(c) && c != CH_LBRK && c != CH_RBRK
                             && c != CH_DOT && c != CH_COLON) flag_bad();
            end
            LN_PATH: path_byte(c);
            LN_ESC: begin
                if (is_hex(c) && esc_pending == 2'd1) begin
                    held_digit  = c;
                    esc_pending = 2'd2;
                end else if (is_hex(c) && esc_pending == 2'd2) begin
                    decoded     = {hex_val(held_digit), hex_val(c)};
                    esc_pending = '0;
                    held_digit  = '0;
                    line_phase  = LN_PATH;
                    if (decoded == 8'd0) flag_bad();
                    else add_data(decoded, hrlp_pkg::KIND_PATH);
                end else begin
                    // Escape cut short: flush the pending text as path bytes
                    add_data(CH_PCT, hrlp_pkg::KIND_PATH);
                    if (esc_pending == 2'd2) add_data(held_digit, hrlp_pkg::KIND_PATH);
                    esc_pending = '0;
                    held_digit  = '0;
                    line_phase  = LN_PATH;
                    path_byte(c);
                end
            end
            LN_QUERY: begin
                if (is_blank(c)) line_phase = LN_VERSION;
                else add_data(c, hrlp_pkg::KIND_QUERY);
            end
            LN_VERSION: begin
                if (c == CH_SLASH) begin
                    major_acc  = '0;
                    minor_acc  = '0;
                    line_phase = LN_MAJOR_WS;
                end else if (c == CH_CR) flag_bad();
            end
            LN_MAJOR_WS: if (!is_blank(c)) major_byte(c);
            LN_MAJOR:    major_byte(c);
            LN_MAJOR_SP: begin
                if (c == CH_DOT) line_phase = LN_MINOR0;
                else flag_bad();
            end
            LN_MINOR0:   if (!is_blank(c)) minor_byte(c);
            LN_MINOR:    minor_byte(c);
            LN_END: begin
                if (c == CH_LF) line_phase = LN_HEADER;
                else if (!is_blank(c)) flag_bad();
            end
            LN_HEADER:   add_data(c, hrlp_pkg::KIND_HEADER);
            default:     line_phase = LN_METHOD_WS;
        endcase
    endfunction

    // Work out the result items of one accepted byte and queue them
    function automatic void predict_results(input logic [7:0] c, input logic fresh);
        hrlp_pkg::t_out_item item;
        if (fresh) clear_line();
        data_n = 0;
        if (line_status == hrlp_pkg::ST_OK) begin
            parse_byte(c);
            if (byte_count != 32'hFFFF_FFFF) byte_count++;
            if (size_limit != 0 && byte_count > size_limit)
                line_status = hrlp_pkg::ST_TOO_LARGE;
        end
        if (data_n == 0) add_data(8'd0, hrlp_pkg::KIND_NONE);
        for (int k = 0; k < data_n; k++) begin
            item.out_byte      = data_byte[k];
            item.out_kind      = data_kind[k];
            item.parse_status  = line_status;
            item.in_headers    = (line_phase == LN_HEADER);
            item.major_version = major_acc;
            item.minor_version = minor_acc;
            item.last_of_run   = (k == data_n - 1);
            expected_items.push_back(item);
        end
    endfunction

    function automatic void report_failure(input string what,
                                           input hrlp_pkg::t_out_item exp_item,
                                           input hrlp_pkg::t_out_item got_item,
                                           input logic show_exp);
        fail_total++;
        if (fail_total <= MAX_REPORTS) begin
            $display("%0t: %s", $realtime, what);
            if (show_exp)
                $display("  expected byte=%02h kind=%0d status=%0d hdr=%0b maj=%0d min=%0d last=%0b",
                         exp_item.out_byte, exp_item.out_kind, exp_item.parse_status,
                         exp_item.in_headers, exp_item.major_version,
                         exp_item.minor_version, exp_item.last_of_run);
            $display("  actual   byte=%02h kind=%0d status=%0d hdr=%0b maj=%0d min=%0d last=%0b",
                     got_item.out_byte, got_item.out_kind, got_item.parse_status,
                     got_item.in_headers, got_item.major_version,
                     got_item.minor_version, got_item.last_of_run);
        end
    endfunction

    // Track config, predict on each accepted byte, compare each accepted result
    always @(posedge i_clk) begin
        hrlp_pkg::t_out_item exp_item;
        hrlp_pkg::t_out_item got_item;
        if (!i_rst_n) begin
            clear_line();
            size_limit = '0;
            expected_items.delete();
        end else begin
            if (i_cfg_wr_en) size_limit = i_cfg_wr_data;
            if (i_req_ch.valid && i_req_ch.ready)
                predict_results(i_req_ch.data.in_byte, i_req_ch.data.new_request);
            if (i_res_ch.valid && i_res_ch.ready) begin
                got_item = i_res_ch.data;
                exp_item = '0;
                if (expected_items.size() == 0) begin
                    report_failure("mismatch: result item with none expected",
                                   exp_item, got_item, 1'b0);
                end else begin
                    exp_item = expected_items.pop_front();
                    if (got_item.out_byte !== exp_item.out_byte
                        || got_item.out_kind !== exp_item.out_kind
                        || got_item.parse_status !== exp_item.parse_status
                        || got_item.in_headers !== exp_item.in_headers
                        || got_item.major_version !== exp_item.major_version
                        || got_item.minor_version !== exp_item.minor_version
                        || got_item.last_of_run !== exp_item.last_of_run)
                        report_failure("mismatch in result item", exp_item, got_item, 1'b1);
                end
            end
        end
        o_pending    <= expected_items.size();
        o_fail_count <= fail_total;
    end

endmodule

>>> bench/tb_top.sv
`timescale 1ns / 1ps
module tb_top;

    localparam int QUIET_LIMIT = 5000;
    localparam int NUM_PHASES  = 5;

    logic        i_clk   = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        cfg_wr_en;
    logic [31:0] cfg_wr_data;

    int          fail_count;
    int          pending;
    int          send_idle_pct  = 0;
    int          recv_stall_pct = 0;
    int          quiet_cycles   = 0;
    int          bytes_sent     = 0;
    logic [7:0]  line_bytes [$];

    hrlp_in_if  req_ch ();
    hrlp_out_if res_ch ();

    http_request_line_parser DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in          (req_ch),
        .o_out         (res_ch),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data)
    );

    hrlp_line_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req_ch      (req_ch),
        .i_res_ch      (res_ch),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Stall the result side at random
    always @(posedge i_clk) begin
        res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Abort when nothing moves for too long
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= QUIET_LIMIT) begin
                $display("FAIL http_request_line_parser");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // Present one byte, hold it until accepted
    task automatic send_byte(input logic [7:0] b, input logic fresh);
        while ($urandom_range(99) < send_idle_pct) begin
            req_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.data  <= '{in_byte: b, new_request: fresh};
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        bytes_sent++;
    endtask

    task automatic send_text(input string s, input logic fresh);
        for (int i = 0; i < s.len(); i++) send_byte(s[i], fresh && i == 0);
    endtask

    // Drop valid and hold off until every expected result has come
    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_size_limit(input logic [31:0] lim);
        wait_drained();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= lim;
        @(posedge i_clk);
        cfg_wr_en   <= 1'b0;
    endtask

    function automatic void put_text(input string s);
        for (int i = 0; i < s.len(); i++) line_bytes.push_back(s[i]);
    endfunction

    function automatic logic [7:0] rand_letter();
        return $urandom_range(1) ? 8'($urandom_range(65, 90)) : 8'($urandom_range(97, 122));
    endfunction

    function automatic logic [7:0] rand_hex();
        string digits;
        digits = "0123456789abcdefABCDEF";
        return digits[$urandom_range(digits.len() - 1)];
    endfunction

    function automatic logic [7:0] rand_method_char();
        string marks;
        marks = "\"(),/:;<=>?@[\\]{}";
        if ($urandom_range(4) == 0) return marks[$urandom_range(marks.len() - 1)];
        return rand_letter();
    endfunction

    function automatic void put_blanks(input int n);
        repeat (n) line_bytes.push_back($urandom_range(1) ? 8'h20 : 8'h09);
    endfunction

    function automatic void put_digits(input int n);
        repeat (n) line_bytes.push_back(8'($urandom_range(48, 57)));
    endfunction

    // Build one request line with random content, mostly well formed
    function automatic void build_request();
        int          mlen;
        int          r;
        logic [7:0]  b;
        string       host_marks;
        line_bytes.delete();
        host_marks = "[].:-";
        if ($urandom_range(9) == 0) begin
            repeat ($urandom_range(1, 12)) line_bytes.push_back(8'($urandom_range(255)));
            return;
        end
        if ($urandom_range(3) == 0) put_blanks($urandom_range(1, 2));
        // method, sometimes past the capacity
        mlen = ($urandom_range(9) == 0) ? $urandom_range(18, 21) : $urandom_range(1, 7);
        repeat (mlen) line_bytes.push_back(rand_method_char());
        if ($urandom_range(19) == 0) line_bytes.push_back(8'($urandom_range(255)));
        line_bytes.push_back(8'h20);
        if ($urandom_range(4) == 0) put_blanks($urandom_range(1, 2));
        // absolute form: scheme and host to be skipped
        if ($urandom_range(3) == 0) begin
            repeat ($urandom_range(1, 5)) line_bytes.push_back(rand_letter());
            put_text(($urandom_range(15) == 0) ? ":/" : "://");
            repeat ($urandom_range(0, 6)) begin
                r = $urandom_range(9);
                if (r < 5) line_bytes.push_back(rand_letter());
                else if (r < 7) put_digits(1);
                else line_bytes.push_back(host_marks[$urandom_range(4)]);
            end
        end
        line_bytes.push_back("/");
        // path with escapes, good and broken
        repeat ($urandom_range(0, 6)) begin
            r = $urandom_range(9);
            if (r < 6) line_bytes.push_back(8'($urandom_range(33, 126)));
            else if (r == 6) line_bytes.push_back(8'($urandom_range(128, 255)));
            else if (r == 7) begin
                line_bytes.push_back("%");
                line_bytes.push_back(rand_hex());
                line_bytes.push_back(rand_hex());
            end else if (r == 8) begin
                line_bytes.push_back("%");
                if ($urandom_range(1)) line_bytes.push_back(rand_hex());
                line_bytes.push_back($urandom_range(1) ? 8'h25 : 8'($urandom_range(103, 126)));
            end else begin
                put_text(($urandom_range(2) == 0) ? "%00" : "%7e");
            end
        end
        if ($urandom_range(2) == 0) begin
            line_bytes.push_back("?");
            repeat ($urandom_range(0, 5)) begin
                b = 8'($urandom_range(255));
                line_bytes.push_back((b == 8'h20 || b == 8'h09) ? 8'h71 : b);
            end
        end
        // line end, plain or with a protocol version
        r = $urandom_range(9);
        if (r == 0) put_text("\r\n");
        else if (r == 1) put_text("\n");
        else begin
            put_blanks($urandom_range(1, 2));
            if ($urandom_range(15) == 0) line_bytes.push_back(($urandom_range(1)) ? 8'h0D : 8'h58);
            put_text("HTTP/");
            if ($urandom_range(4) == 0) put_blanks($urandom_range(1, 2));
            put_digits(($urandom_range(7) == 0) ? $urandom_range(3, 5) : $urandom_range(0, 1) + 1);
            if ($urandom_range(7) == 0) put_blanks(1);
            if ($urandom_range(15) == 0) line_bytes.push_back(8'($urandom_range(255)));
            line_bytes.push_back(".");
            if ($urandom_range(4) == 0) put_blanks($urandom_range(1, 2));
            put_digits(($urandom_range(7) == 0) ? $urandom_range(3, 5) : 1);
            case ($urandom_range(3))
                0: put_text("\r\n");
                1: put_text("\n");
                2: put_text(" \r\n");
                default: put_text("\t\n");
            endcase
        end
        repeat ($urandom_range(0, 6)) line_bytes.push_back(8'($urandom_range(255)));
    endfunction

    // Send requests until the byte budget of this phase is spent
    task automatic run_requests(input int budget);
        int   stop_at;
        logic fresh;
        stop_at = bytes_sent + budget;
        while (bytes_sent < stop_at) begin
            build_request();
            foreach (line_bytes[i]) begin
                fresh = (i == 0) ? ($urandom_range(9) != 0) : ($urandom_range(199) == 0);
                send_byte(line_bytes[i], fresh);
            end
        end
    endtask

    initial begin
        logic [31:0] limits   [NUM_PHASES];
        int          budgets  [NUM_PHASES];
        int          idle_pct [NUM_PHASES];
        int          stall_pct[NUM_PHASES];

        limits    = '{32'd0, 32'($urandom_range(6, 40)), 32'hFFFF_FFFF, 32'd1,
                      32'($urandom_range(24, 60))};
        budgets   = '{60, 75, 75, 20, 95};
        idle_pct  = '{0, 74, 0, 22, 22};
        stall_pct = '{0, 0, 74, 22, 22};

        req_ch.valid <= 1'b0;
        req_ch.data  <= '0;
        cfg_wr_en    <= 1'b0;
        cfg_wr_data  <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int p = 0; p < NUM_PHASES; p++) begin
            set_size_limit(limits[p]);
            send_idle_pct  = idle_pct[p];
            recv_stall_pct = stall_pct[p];
            if (p == 0) begin
                // Sticky error from a bad leading byte
                send_byte(8'h00, 1'b1);
                send_byte("A", 1'b0);
                // Decoded zero
                send_text("P /%00", 1'b1);
                // Escapes cut short, high path byte, saturated major, header byte
                send_text("G /%%41%4z", 1'b1);
                send_byte(8'hFF, 1'b0);
                send_text(" H/ 300.7\n", 1'b0);
                send_byte(8'h80, 1'b0);
            end
            run_requests(budgets[p]);
        end

        wait_drained();
        repeat (8) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("PASS http_request_line_parser");
        end else begin
            $display("FAIL http_request_line_parser");
        end
        $finish;
    end

endmodule
